// ===== src/snp_pkg.sv =====
// ----------------------------------------------------------------------------
// snp_pkg
// Shared constants for the SIMD saturating narrow-pack block: the mode codes
// and the source element width codes.
// ----------------------------------------------------------------------------
`default_nettype none

package snp_pkg;

   localparam int unsigned WORD_BITS = 32;

   localparam logic [1:0] OP_TRUNC = 2'd0;
   localparam logic [1:0] OP_SSAT  = 2'd1;
   localparam logic [1:0] OP_USAT  = 2'd2;

   localparam logic [1:0] WSEL_32 = 2'd0;
   localparam logic [1:0] WSEL_16 = 2'd1;
   localparam logic [1:0] WSEL_8  = 2'd2;
   localparam logic [1:0] WSEL_4  = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;

endpackage

`default_nettype wire

// ===== src/simd_narrow_pack_saturate.sv =====
// ----------------------------------------------------------------------------
// simd_narrow_pack_saturate
// Narrows the packed elements of two 32-bit source words to half width and
// packs them into one 32-bit result, by truncation or by signed or unsigned
// saturation.
//
// The request channel (req_) carries the mode, the source element width and
// the two source words. The response channel (rsp_) carries the packed
// result. Both channels use valid/ready, and a transfer happens on a rising
// clock edge where valid and ready are both high.
// A request is captured into an input register; the narrowing logic sits
// between that register and the result register. The result is offered from
// the clock edge after the request transfer if the result register is empty
// or rsp_ready is high then. One request can be taken every cycle as long as
// the receiver keeps rsp_ready high.
// When the receiver stalls, the result register holds its transfer and the
// input register can still take one more request; req_ready drops only when
// both registers are occupied and rsp_ready is low.
// A synchronous reset empties both stages; no result is offered until a new
// request is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module simd_narrow_pack_saturate (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [1:0]  req_width_sel,
   input  wire logic [31:0] req_src_a,
   input  wire logic [31:0] req_src_b,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_result
);

   logic                in_valid_ff;
   logic                in_valid_in;
   logic [1:0]          op_ff;
   logic [1:0]          width_sel_ff;
   snp_pkg::word_type   src_a_ff;
   snp_pkg::word_type   src_b_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   snp_pkg::word_type   result_ff;
   snp_pkg::word_type   result_in;
   logic                advance;
   logic                req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff        <= req_op;
         width_sel_ff <= req_width_sel;
         src_a_ff     <= req_src_a;
         src_b_ff     <= req_src_b;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   // The two sources form one 64-bit element stream: element k sits at
   // bit k*W of {b, a} and its narrowed value goes to bit k*W/2 of the result.
   always_comb begin
      logic [63:0] src;
      logic [31:0] r32;
      logic [31:0] r16;
      logic [31:0] r8;
      logic [31:0] r4;
      logic [31:0] e32;
      logic [15:0] e16;
      logic [7:0]  e8;
      logic [3:0]  e4;
      src = {src_b_ff, src_a_ff};
      r32 = '0;
      r16 = '0;
      r8  = '0;
      r4  = '0;
      for (int k = 0; k < 2; k++) begin
         e32 = src[k*32 +: 32];
         unique case (op_ff)
            snp_pkg::OP_SSAT: begin
               if (e32[31:15] == {17{e32[31]}}) r32[k*16 +: 16] = e32[15:0];
               else r32[k*16 +: 16] = {e32[31], {15{!e32[31]}}};
            end
            snp_pkg::OP_USAT: begin
               if (e32[31:16] == '0) r32[k*16 +: 16] = e32[15:0];
               else r32[k*16 +: 16] = '1;
            end
            default: r32[k*16 +: 16] = e32[15:0];
         endcase
      end
      for (int k = 0; k < 4; k++) begin
         e16 = src[k*16 +: 16];
         unique case (op_ff)
            snp_pkg::OP_SSAT: begin
               if (e16[15:7] == {9{e16[15]}}) r16[k*8 +: 8] = e16[7:0];
               else r16[k*8 +: 8] = {e16[15], {7{!e16[15]}}};
            end
            snp_pkg::OP_USAT: begin
               if (e16[15:8] == '0) r16[k*8 +: 8] = e16[7:0];
               else r16[k*8 +: 8] = '1;
            end
            default: r16[k*8 +: 8] = e16[7:0];
         endcase
      end
      for (int k = 0; k < 8; k++) begin
         e8 = src[k*8 +: 8];
         unique case (op_ff)
            snp_pkg::OP_SSAT: begin
               if (e8[7:3] == {5{e8[7]}}) r8[k*4 +: 4] = e8[3:0];
               else r8[k*4 +: 4] = {e8[7], {3{!e8[7]}}};
            end
            snp_pkg::OP_USAT: begin
               if (e8[7:4] == '0) r8[k*4 +: 4] = e8[3:0];
               else r8[k*4 +: 4] = '1;
            end
            default: r8[k*4 +: 4] = e8[3:0];
         endcase
      end
      for (int k = 0; k < 16; k++) begin
         e4 = src[k*4 +: 4];
         unique case (op_ff)
            snp_pkg::OP_SSAT: begin
               if (e4[3:1] == {3{e4[3]}}) r4[k*2 +: 2] = e4[1:0];
               else r4[k*2 +: 2] = {e4[3], !e4[3]};
            end
            snp_pkg::OP_USAT: begin
               if (e4[3:2] == '0) r4[k*2 +: 2] = e4[1:0];
               else r4[k*2 +: 2] = '1;
            end
            default: r4[k*2 +: 2] = e4[1:0];
         endcase
      end
      unique case (width_sel_ff)
         snp_pkg::WSEL_32: result_in = r32;
         snp_pkg::WSEL_16: result_in = r16;
         snp_pkg::WSEL_8:  result_in = r8;
         snp_pkg::WSEL_4:  result_in = r4;
         default:          result_in = r32;
      endcase
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = result_ff;

   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("request side blocked while a stage is free");

   a_take_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("transferred request not held in the input register");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result register empty after an advance");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=>
         (in_valid_ff && $stable(src_a_ff) && $stable(src_b_ff) && $stable(op_ff)))
      else $error("waiting input register changed");

endmodule

`default_nettype wire
